// ===== rtl/core/pidtpd_pkg.sv =====
// Shared types and constants for the PID temperature / PWM duty block.
// No dependencies; used by pidtpd_seq, pid_temperature_pwm_duty and the bench.
`timescale 1ns / 1ps

package pidtpd_pkg;

   // Fixed field widths
   localparam int GAIN_W  = 16;   // gains, temp scale, period
   localparam int SET_W   = 16;   // setpoint, signed Q8.8
   localparam int TEMP_W  = 18;   // saturated temperature
   localparam int ERR_W   = 19;   // setpoint - temperature
   localparam int DT_W    = 19;   // temperature - previous
   localparam int INT_W   = 21;   // integral state and its limits
   localparam int SUM_W   = 22;   // integral + error before clamp
   localparam int ACC_W   = 40;   // controller accumulator
   localparam int OUT_W   = 16;   // drive / duty words
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 21;

   localparam int TEMP_MAX = 131071;
   localparam int TEMP_MIN = -131072;
   localparam int DRIVE_SAT = 32767;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SETPOINT     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_P_GAIN       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_I_GAIN       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_D_GAIN       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEGRAL_MAX = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEGRAL_MIN = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_SCALE   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_PERIOD  = 3'd7;

   // Operand pair fed to the shared multiplier
   typedef enum logic [1:0] {
      MUL_SCALE = 2'd0,   // counts * temp_scale
      MUL_P     = 2'd1,   // p_gain * error
      MUL_I     = 2'd2,   // i_gain * integral
      MUL_D     = 2'd3    // d_gain * delta temperature
   } mul_sel_type;

   // Step strobes from the sequencer to the datapath
   typedef struct packed {
      logic        accept;
      mul_sel_type mul_sel;
      logic        step_temp;
      logic        acc_load;
      logic        acc_add;
      logic        acc_sub;
      logic        step_trunc;
      logic        step_out;
   } ctrl_type;

endpackage

// ===== rtl/core/pidtpd_mul.sv =====
// Shared multiplier: unsigned gain times signed operand, product registered.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module pidtpd_mul #(
   parameter int A_W = 16,
   parameter int B_W = 21
) (
   input  logic                   clock,
   input  logic [A_W-1:0]         mul_a,
   input  logic signed [B_W-1:0]  mul_b,
   output logic signed [A_W+B_W:0] mul_prod
);

   logic signed [A_W+B_W:0] prod_ff;
   logic signed [A_W+B_W:0] prod_in;

   // gain is unsigned: zero-extend by one bit before the signed multiply
   assign prod_in = $signed({1'b0, mul_a}) * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_prod = prod_ff;

endmodule

// ===== rtl/core/pidtpd_seq.sv =====
// Step sequencer for the PID block: one-hot FSM walking the shared multiplier.
// Depends on pidtpd_pkg (ctrl_type, mul_sel_type).
`timescale 1ns / 1ps

module pidtpd_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 out_free,
   output logic                 req_ready,
   output pidtpd_pkg::ctrl_type ctrl
);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_SCALE = 9'b000000010,
      ST_TEMP  = 9'b000000100,
      ST_PMUL  = 9'b000001000,
      ST_IMUL  = 9'b000010000,
      ST_DMUL  = 9'b000100000,
      ST_DACC  = 9'b001000000,
      ST_TRUNC = 9'b010000000,
      ST_DONE  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      ctrl.mul_sel = pidtpd_pkg::MUL_SCALE;
      unique case (state_ff)
         ST_IDLE: begin
            ctrl.accept = req_valid;
            if (req_valid) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            ctrl.mul_sel = pidtpd_pkg::MUL_SCALE;
            state_in     = ST_TEMP;
         end
         ST_TEMP: begin
            ctrl.step_temp = 1'b1;
            state_in       = ST_PMUL;
         end
         ST_PMUL: begin
            ctrl.mul_sel = pidtpd_pkg::MUL_P;
            state_in     = ST_IMUL;
         end
         ST_IMUL: begin
            ctrl.acc_load = 1'b1;
            ctrl.mul_sel  = pidtpd_pkg::MUL_I;
            state_in      = ST_DMUL;
         end
         ST_DMUL: begin
            ctrl.acc_add = 1'b1;
            ctrl.mul_sel = pidtpd_pkg::MUL_D;
            state_in     = ST_DACC;
         end
         ST_DACC: begin
            ctrl.acc_sub = 1'b1;
            state_in     = ST_TRUNC;
         end
         ST_TRUNC: begin
            ctrl.step_trunc = 1'b1;
            state_in        = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register can take the word
            if (out_free) begin
               ctrl.step_out = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/pid_temperature_pwm_duty.sv =====
// PID temperature controller with inverted PWM duty output (top level).
// A req word is accepted only while the sequencer is idle, and the next one only once
// it is through: four products pass one at a time through the shared multiplier.
// The output register frees the req side: a new word is taken while a result waits.
// Reset (synchronous, active high): registers to defaults, integral and previous
// temperature to zero, sequencer idle, no result pending.
// Depends on pidtpd_pkg, pidtpd_mul, pidtpd_seq.
`timescale 1ns / 1ps

module pid_temperature_pwm_duty #(
   parameter int FRAC_BITS    = 8,
   parameter int SENSOR_WIDTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // sensor words
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [SENSOR_WIDTH-1:0]         req_sensor_word,
   // duty words
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [pidtpd_pkg::OUT_W-1:0]           rsp_duty_count,
   output logic [pidtpd_pkg::OUT_W-1:0]           rsp_drive_level,
   output logic                                   rsp_drive_clamped,
   // register writes
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [pidtpd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pidtpd_pkg::CSR_DAT_W-1:0]       csr_data
);

   localparam int GAIN_W = pidtpd_pkg::GAIN_W;
   localparam int SET_W  = pidtpd_pkg::SET_W;
   localparam int TEMP_W = pidtpd_pkg::TEMP_W;
   localparam int ERR_W  = pidtpd_pkg::ERR_W;
   localparam int DT_W   = pidtpd_pkg::DT_W;
   localparam int INT_W  = pidtpd_pkg::INT_W;
   localparam int SUM_W  = pidtpd_pkg::SUM_W;
   localparam int ACC_W  = pidtpd_pkg::ACC_W;
   localparam int OUT_W  = pidtpd_pkg::OUT_W;

   // sensor counts after the >>4, and multiplier operand / product widths
   localparam int CNT_W = SENSOR_WIDTH - 4;
   localparam int B_W   = (CNT_W > INT_W) ? CNT_W : INT_W;
   localparam int P_W   = GAIN_W + B_W + 1;
   localparam int TSHIFT = 16 - FRAC_BITS;
   localparam int WH_W  = ACC_W - FRAC_BITS;

   localparam logic signed [P_W-1:0] TMAX_P = P_W'(pidtpd_pkg::TEMP_MAX);
   localparam logic signed [P_W-1:0] TMIN_P = P_W'(pidtpd_pkg::TEMP_MIN);
   localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'((2 ** FRAC_BITS) - 1);
   localparam logic [OUT_W-1:0] SAT_HI = OUT_W'(pidtpd_pkg::DRIVE_SAT);

   // ------------------------------------------------------------------
   // Configuration registers; writes always accepted
   // ------------------------------------------------------------------
   logic signed [SET_W-1:0]  setpoint_ff;
   logic [GAIN_W-1:0]        p_gain_ff, i_gain_ff, d_gain_ff, temp_scale_ff, period_ff;
   logic signed [INT_W-1:0]  int_max_ff, int_min_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff   <= SET_W'(10240);
         p_gain_ff     <= GAIN_W'(100);
         i_gain_ff     <= GAIN_W'(2);
         d_gain_ff     <= GAIN_W'(10);
         int_max_ff    <= INT_W'(255744);
         int_min_ff    <= '0;
         temp_scale_ff <= GAIN_W'(4116);
         period_ff     <= GAIN_W'(1000);
      end else if (csr_valid) begin
         unique case (csr_index)
            pidtpd_pkg::CSR_SETPOINT:     setpoint_ff   <= csr_data[SET_W-1:0];
            pidtpd_pkg::CSR_P_GAIN:       p_gain_ff     <= csr_data[GAIN_W-1:0];
            pidtpd_pkg::CSR_I_GAIN:       i_gain_ff     <= csr_data[GAIN_W-1:0];
            pidtpd_pkg::CSR_D_GAIN:       d_gain_ff     <= csr_data[GAIN_W-1:0];
            pidtpd_pkg::CSR_INTEGRAL_MAX: int_max_ff    <= csr_data[INT_W-1:0];
            pidtpd_pkg::CSR_INTEGRAL_MIN: int_min_ff    <= csr_data[INT_W-1:0];
            pidtpd_pkg::CSR_TEMP_SCALE:   temp_scale_ff <= csr_data[GAIN_W-1:0];
            pidtpd_pkg::CSR_DUTY_PERIOD:  period_ff     <= csr_data[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   pidtpd_pkg::ctrl_type ctrl;
   logic                 out_free;
   logic                 rsp_valid_ff;

   // output register empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   pidtpd_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .req_ready (req_ready),
      .ctrl      (ctrl)
   );

   // ------------------------------------------------------------------
   // Shared multiplier with operand select
   // ------------------------------------------------------------------
   logic signed [CNT_W-1:0]  counts_ff;
   logic signed [ERR_W-1:0]  err_ff;
   logic signed [DT_W-1:0]   dt_ff;
   logic signed [INT_W-1:0]  integral_ff;
   logic [GAIN_W-1:0]        mul_a;
   logic signed [B_W-1:0]    mul_b;
   logic signed [P_W-1:0]    mul_prod;

   always_comb begin
      unique case (ctrl.mul_sel)
         pidtpd_pkg::MUL_SCALE: begin
            mul_a = temp_scale_ff;
            mul_b = B_W'(counts_ff);
         end
         pidtpd_pkg::MUL_P: begin
            mul_a = p_gain_ff;
            mul_b = B_W'(err_ff);
         end
         pidtpd_pkg::MUL_I: begin
            mul_a = i_gain_ff;
            mul_b = B_W'(integral_ff);
         end
         pidtpd_pkg::MUL_D: begin
            mul_a = d_gain_ff;
            mul_b = B_W'(dt_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   pidtpd_mul #(
      .A_W (GAIN_W),
      .B_W (B_W)
   ) u_mul (
      .clock    (clock),
      .mul_a    (mul_a),
      .mul_b    (mul_b),
      .mul_prod (mul_prod)
   );

   // ------------------------------------------------------------------
   // Temperature, error, integral, delta (one step after the scale product)
   // ------------------------------------------------------------------
   logic signed [P_W-1:0]    temp_wide;
   logic signed [TEMP_W-1:0] temp;
   logic signed [TEMP_W-1:0] prev_ff;
   logic signed [ERR_W-1:0]  err_in;
   logic signed [DT_W-1:0]   dt_in;
   logic signed [SUM_W-1:0]  isum;
   logic signed [INT_W-1:0]  integral_in;

   always_comb begin
      // floor shift to Q.FRAC_BITS, then saturate to the temperature range
      temp_wide = mul_prod >>> TSHIFT;
      if (temp_wide > TMAX_P) begin
         temp = TEMP_W'(TMAX_P);
      end else if (temp_wide < TMIN_P) begin
         temp = TEMP_W'(TMIN_P);
      end else begin
         temp = temp_wide[TEMP_W-1:0];
      end

      err_in = ERR_W'(setpoint_ff) - ERR_W'(temp);
      dt_in  = DT_W'(temp) - DT_W'(prev_ff);
      isum   = SUM_W'(integral_ff) + SUM_W'(err_in);

      // max test first: it wins when the limits cross
      if (isum > SUM_W'(int_max_ff)) begin
         integral_in = int_max_ff;
      end else if (isum < SUM_W'(int_min_ff)) begin
         integral_in = int_min_ff;
      end else begin
         integral_in = isum[INT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integral_ff <= '0;
         prev_ff     <= '0;
      end else if (ctrl.step_temp) begin
         integral_ff <= integral_in;
         prev_ff     <= temp;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         counts_ff <= CNT_W'(req_sensor_word >>> 4);
      end
      if (ctrl.step_temp) begin
         err_ff <= err_in;
         dt_ff  <= dt_in;
      end
   end

   // ------------------------------------------------------------------
   // Accumulator: P + I - D, then truncate toward zero
   // ------------------------------------------------------------------
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ACC_W-1:0] prod_acc;
   logic signed [ACC_W-1:0] acc_biased;
   logic signed [WH_W-1:0]  whole_ff;

   assign prod_acc = ACC_W'(mul_prod);

   always_comb begin
      priority if (ctrl.acc_load) begin
         acc_in = prod_acc;
      end else if (ctrl.acc_add) begin
         acc_in = acc_ff + prod_acc;
      end else if (ctrl.acc_sub) begin
         acc_in = acc_ff - prod_acc;
      end else begin
         acc_in = acc_ff;
      end
   end

   // negative values get 2^F-1 added so the arithmetic shift rounds toward zero
   assign acc_biased = acc_ff + (acc_ff[ACC_W-1] ? RND_BIAS : '0);

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (ctrl.step_trunc) begin
         whole_ff <= WH_W'(acc_biased >>> FRAC_BITS);
      end
   end

   // ------------------------------------------------------------------
   // Clamp to 0..min(32767, period), invert, output register
   // ------------------------------------------------------------------
   logic [OUT_W-1:0] drive_cap;
   logic [OUT_W-1:0] drive;
   logic             clamped;
   logic [OUT_W-1:0] duty_ff, drive_ff;
   logic             clamped_ff;

   always_comb begin
      drive_cap = (period_ff > SAT_HI) ? SAT_HI : period_ff;
      if (whole_ff[WH_W-1]) begin
         drive   = '0;
         clamped = 1'b1;
      end else if (whole_ff > $signed(WH_W'(drive_cap))) begin
         drive   = drive_cap;
         clamped = 1'b1;
      end else begin
         drive   = whole_ff[OUT_W-1:0];
         clamped = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.step_out) begin
         duty_ff    <= period_ff - drive;
         drive_ff   <= drive;
         clamped_ff <= clamped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.step_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_duty_count    = duty_ff;
   assign rsp_drive_level   = drive_ff;
   assign rsp_drive_clamped = clamped_ff;

endmodule

// ===== bench/tb_pid_temperature_pwm_duty.sv =====
// Self-checking bench for the PID temperature controller with inverted PWM duty.
// Depends on pidtpd_pkg and pid_temperature_pwm_duty; carries its own controller
// predictor and checks every duty word field by field.
`timescale 1ns / 1ps

module tb_pid_temperature_pwm_duty;

   localparam int OUT_W  = pidtpd_pkg::OUT_W;
   localparam int SET_W  = pidtpd_pkg::SET_W;
   localparam int GAIN_W = pidtpd_pkg::GAIN_W;
   localparam int INT_W  = pidtpd_pkg::INT_W;
   localparam int TEMP_W = pidtpd_pkg::TEMP_W;
   localparam int IDX_W  = pidtpd_pkg::CSR_IDX_W;
   localparam int DAT_W  = pidtpd_pkg::CSR_DAT_W;

   // Predictor fixed point: Q.8 temperatures, 4 status bits below the sensor count
   localparam int FRAC         = 8;
   localparam int SCALE_SHIFT  = 16 - FRAC;
   localparam int COUNT_SHIFT  = 4;
   // Register values after reset
   localparam int RST_SETPOINT = 10240;
   localparam int RST_P_GAIN   = 100;
   localparam int RST_I_GAIN   = 2;
   localparam int RST_D_GAIN   = 10;
   localparam int RST_INT_MAX  = 255744;
   localparam int RST_INT_MIN  = 0;
   localparam int RST_SCALE    = 4116;
   localparam int RST_PERIOD   = 1000;
   // Bench timing: quiet stretch after draining, watchdog limit, random phase sizes
   localparam int SETTLE_CYCLES = 12;
   localparam int WATCH_LIMIT   = 2000;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_WORDS   = 58;

   typedef struct packed {
      logic [OUT_W-1:0] duty_count;
      logic [OUT_W-1:0] drive_level;
      logic             drive_clamped;
   } duty_word_type;

   logic clock = 1'b0;
   logic reset;

   logic                     req_valid;
   logic                     req_ready;
   logic signed [15:0]       req_sensor_word;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [OUT_W-1:0]         rsp_duty_count;
   logic [OUT_W-1:0]         rsp_drive_level;
   logic                     rsp_drive_clamped;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [IDX_W-1:0]         csr_index;
   logic [DAT_W-1:0]         csr_data;

   // Predictor copy of the registers and of the controller state
   logic signed [SET_W-1:0]  setpoint_r;
   logic [GAIN_W-1:0]        p_gain_r;
   logic [GAIN_W-1:0]        i_gain_r;
   logic [GAIN_W-1:0]        d_gain_r;
   logic signed [INT_W-1:0]  integral_max_r;
   logic signed [INT_W-1:0]  integral_min_r;
   logic [GAIN_W-1:0]        temp_scale_r;
   logic [GAIN_W-1:0]        duty_period_r;
   logic signed [INT_W-1:0]  integral_r;
   logic signed [TEMP_W-1:0] last_temp_r;

   duty_word_type expected_duty[$];
   int         errors = 0;
   int         stalled_cycles = 0;
   bit         no_idle = 1'b0;   // set for stretches where neither side pauses

   pid_temperature_pwm_duty dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sensor_word   (req_sensor_word),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_duty_count    (rsp_duty_count),
      .rsp_drive_level   (rsp_drive_level),
      .rsp_drive_clamped (rsp_drive_clamped),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   function automatic void reset_model();
      setpoint_r     = SET_W'(RST_SETPOINT);
      p_gain_r       = GAIN_W'(RST_P_GAIN);
      i_gain_r       = GAIN_W'(RST_I_GAIN);
      d_gain_r       = GAIN_W'(RST_D_GAIN);
      integral_max_r = INT_W'(RST_INT_MAX);
      integral_min_r = INT_W'(RST_INT_MIN);
      temp_scale_r   = GAIN_W'(RST_SCALE);
      duty_period_r  = GAIN_W'(RST_PERIOD);
      integral_r     = '0;
      last_temp_r    = '0;
   endfunction

   // Register write as the block sees it: narrow registers keep the low bits
   function automatic void apply_reg(input logic [IDX_W-1:0] idx,
                                     input logic [DAT_W-1:0] data);
      case (idx)
         pidtpd_pkg::CSR_SETPOINT:     setpoint_r     = data[SET_W-1:0];
         pidtpd_pkg::CSR_P_GAIN:       p_gain_r       = data[GAIN_W-1:0];
         pidtpd_pkg::CSR_I_GAIN:       i_gain_r       = data[GAIN_W-1:0];
         pidtpd_pkg::CSR_D_GAIN:       d_gain_r       = data[GAIN_W-1:0];
         pidtpd_pkg::CSR_INTEGRAL_MAX: integral_max_r = data[INT_W-1:0];
         pidtpd_pkg::CSR_INTEGRAL_MIN: integral_min_r = data[INT_W-1:0];
         pidtpd_pkg::CSR_TEMP_SCALE:   temp_scale_r   = data[GAIN_W-1:0];
         pidtpd_pkg::CSR_DUTY_PERIOD:  duty_period_r  = data[GAIN_W-1:0];
         default: ;
      endcase
   endfunction

   // One controller step: returns the duty word and advances integral / last temp
   function automatic duty_word_type next_duty(input logic signed [15:0] sensor);
      longint        counts, temp, err, isum, acc, whole, drv;
      duty_word_type r;
      counts = longint'(sensor) >>> COUNT_SHIFT;
      temp   = (counts * longint'(temp_scale_r)) >>> SCALE_SHIFT;
      if (temp > pidtpd_pkg::TEMP_MAX) temp = pidtpd_pkg::TEMP_MAX;
      else if (temp < pidtpd_pkg::TEMP_MIN) temp = pidtpd_pkg::TEMP_MIN;
      err  = longint'(setpoint_r) - temp;
      isum = longint'(integral_r) + err;
      // upper limit is tested first, so it wins when the limits cross
      if (isum > longint'(integral_max_r)) isum = longint'(integral_max_r);
      else if (isum < longint'(integral_min_r)) isum = longint'(integral_min_r);
      integral_r = INT_W'(isum);
      acc = longint'(p_gain_r) * err + longint'(i_gain_r) * isum
            - longint'(d_gain_r) * (temp - longint'(last_temp_r));
      last_temp_r = TEMP_W'(temp);
      // drop the fraction toward zero, not toward minus infinity
      if (acc < 0) whole = -((-acc) >>> FRAC);
      else whole = acc >>> FRAC;
      drv = whole;
      if (drv > pidtpd_pkg::DRIVE_SAT) drv = pidtpd_pkg::DRIVE_SAT;
      else if (drv < -pidtpd_pkg::DRIVE_SAT - 1) drv = -pidtpd_pkg::DRIVE_SAT - 1;
      if (drv > longint'(duty_period_r)) drv = longint'(duty_period_r);
      else if (drv < 0) drv = 0;
      r.drive_clamped = (drv != whole);
      r.drive_level   = OUT_W'(drv);
      r.duty_count    = OUT_W'(longint'(duty_period_r) - drv);
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Handshake helpers
   // ------------------------------------------------------------------

   // Mostly back to back or short pauses, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 50) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // Valid is left high after a word goes in so the next word can follow at
   // once; anything else that spends time drops it first, in that same step.
   task automatic req_release();
      if (req_valid) req_valid <= 1'b0;
   endtask

   task automatic send_word(input logic signed [15:0] word);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_sensor_word <= word;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_duty.push_back(next_duty(word));
   endtask

   // Drain every outstanding duty word, then let the block go quiet
   task automatic wait_idle();
      req_release();
      while (expected_duty.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] idx,
                            input logic [DAT_W-1:0] data);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_reg(idx, data);
      csr_valid <= 1'b0;
   endtask

   task automatic set_all(input int setpoint,
                          input int p_gain,
                          input int i_gain,
                          input int d_gain,
                          input int int_max,
                          input int int_min,
                          input int scale,
                          input int period);
      write_reg(pidtpd_pkg::CSR_SETPOINT, DAT_W'(setpoint));
      write_reg(pidtpd_pkg::CSR_P_GAIN, DAT_W'(p_gain));
      write_reg(pidtpd_pkg::CSR_I_GAIN, DAT_W'(i_gain));
      write_reg(pidtpd_pkg::CSR_D_GAIN, DAT_W'(d_gain));
      write_reg(pidtpd_pkg::CSR_INTEGRAL_MAX, DAT_W'(int_max));
      write_reg(pidtpd_pkg::CSR_INTEGRAL_MIN, DAT_W'(int_min));
      write_reg(pidtpd_pkg::CSR_TEMP_SCALE, DAT_W'(scale));
      write_reg(pidtpd_pkg::CSR_DUTY_PERIOD, DAT_W'(period));
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset register values with the sensor word at its corners and near 40 C
   task automatic test_reset_values();
      send_word(16'sh7FFF);
      send_word(16'sh8000);
      send_word(16'sh0000);
      send_word(16'shFFFF);   // -1 shifts to count -1, not 0
      send_word(16'sh000F);   // status bits only
      send_word(16'sh0010);
      send_word(16'shFFF0);
      send_word(16'sh5555);
      send_word(16'shAAAA);
      send_word(16'sh27D0);   // close to the default setpoint
   endtask

   task automatic test_corner_settings();
      // integral limits crossed: the upper limit has priority
      set_all(0, 1, 1, 0, -1000, 1000, RST_SCALE, RST_PERIOD);
      send_word(16'sh7FFF);
      send_word(16'sh8000);
      // every gain and the scale at full range: temperature and drive saturate
      set_all(-32768, 65535, 65535, 65535, 1048575, -1048576, 65535, 65535);
      send_word(16'sh7FFF);
      send_word(16'sh8000);
      send_word(16'sh0000);
      send_word(16'sh7FFF);
      // zero period: drive and duty both held at zero
      set_all(32767, 100, 0, 0, 0, 0, 0, 0);
      send_word(16'sh0000);
      send_word(16'sh7FFF);
      // unit scale, unit P, period 1: small sums around the truncation point
      set_all(0, 1, 0, 0, 0, 0, 256, 1);
      send_word(16'sh0640);   // sum -100 truncates to 0
      send_word(-16'sd4800);  // sum 300 gives exactly the period
      send_word(16'sd4800);   // sum -300 truncates to -1, clamped up
      send_word(16'shFFFF);
      // derivative only, big swings in temperature
      set_all(0, 0, 0, 65535, 0, 0, 65535, 65535);
      send_word(16'sh8000);
      send_word(16'sh7FFF);
   endtask

   // Register settings: a quarter of them at an extreme, the rest in a
   // plausible range; the unused upper data bits carry noise.
   task automatic random_settings();
      logic [DAT_W-1:0] data;
      bit               edge_pick, hi_pick;
      for (int n = int'(pidtpd_pkg::CSR_SETPOINT);
           n <= int'(pidtpd_pkg::CSR_DUTY_PERIOD); n++) begin
         data      = DAT_W'($urandom);
         edge_pick = ($urandom_range(0, 3) == 0);
         hi_pick   = 1'($urandom_range(0, 1));
         case (IDX_W'(n))
            pidtpd_pkg::CSR_SETPOINT:
               data[15:0] = edge_pick ? (hi_pick ? 16'h7FFF : 16'h8000)
                                      : 16'($urandom_range(0, 25600));
            pidtpd_pkg::CSR_P_GAIN:
               data[15:0] = edge_pick ? (hi_pick ? 16'hFFFF : 16'h0000)
                                      : 16'($urandom_range(0, 400));
            pidtpd_pkg::CSR_I_GAIN:
               data[15:0] = edge_pick ? (hi_pick ? 16'hFFFF : 16'h0000)
                                      : 16'($urandom_range(0, 10));
            pidtpd_pkg::CSR_D_GAIN:
               data[15:0] = edge_pick ? (hi_pick ? 16'hFFFF : 16'h0000)
                                      : 16'($urandom_range(0, 50));
            pidtpd_pkg::CSR_INTEGRAL_MAX:
               data = edge_pick ? (hi_pick ? 21'h0FFFFF : 21'h100000)
                                : DAT_W'($urandom_range(0, 400000));
            pidtpd_pkg::CSR_INTEGRAL_MIN:
               data = edge_pick ? (hi_pick ? 21'h0FFFFF : 21'h100000)
                                : -DAT_W'($urandom_range(0, 50000));
            pidtpd_pkg::CSR_TEMP_SCALE:
               data[15:0] = edge_pick ? (hi_pick ? 16'hFFFF : 16'h0000)
                                      : 16'($urandom_range(2000, 8000));
            pidtpd_pkg::CSR_DUTY_PERIOD:
               data[15:0] = edge_pick ? 16'($urandom_range(0, 1) ? 16'hFFFF
                                           : 16'($urandom_range(0, 1)))
                                      : 16'($urandom_range(100, 4000));
            default: ;
         endcase
         write_reg(IDX_W'(n), data);
      end
   endtask

   // Sensor words mostly hover around the count that meets the setpoint, so
   // the loop runs unsaturated; the rest are raw noise and corner words.
   task automatic random_phase(input int words, input bit steady, input bit drain_midway);
      longint             center, cnt;
      int                 roll;
      logic signed [15:0] word;
      no_idle = steady;
      for (int n = 0; n < words; n++) begin
         roll = $urandom_range(0, 9);
         if (roll == 0) begin
            word = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         end else if (roll < 4) begin
            word = 16'($urandom);
         end else begin
            center = (temp_scale_r == 0) ? 0
                     : (longint'(setpoint_r) * 256) / longint'(temp_scale_r);
            cnt = center + longint'($urandom_range(0, 200)) - 100;
            if (cnt > 2047) cnt = 2047;
            else if (cnt < -2048) cnt = -2048;
            word = 16'(cnt * 16 + longint'($urandom_range(0, 15)));
         end
         send_word(word);
         // hold the sender off until every duty word is back
         if (drain_midway && n == words / 2) wait_idle();
      end
      no_idle = 1'b0;
   endtask

   task automatic test_random_settings();
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         random_settings();
         random_phase(PHASE_WORDS, (ph % 4) == 2, ph == 5);
      end
   endtask

   // ------------------------------------------------------------------
   // Result side: random stalls, then compare against the oldest prediction
   // ------------------------------------------------------------------

   initial begin : rsp_stall
      int gap;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         gap = pick_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   always @(posedge clock) begin : check_duty
      duty_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_duty.size() == 0) begin
            $display("%0t: duty word with none expected: duty %0d drive %0d clamped %0b",
                     $time, rsp_duty_count, rsp_drive_level, rsp_drive_clamped);
            errors++;
         end else begin
            want = expected_duty.pop_front();
            if (rsp_duty_count !== want.duty_count) begin
               $display("%0t: duty_count expected %0d actual %0d",
                        $time, want.duty_count, rsp_duty_count);
               errors++;
            end
            if (rsp_drive_level !== want.drive_level) begin
               $display("%0t: drive_level expected %0d actual %0d",
                        $time, want.drive_level, rsp_drive_level);
               errors++;
            end
            if (rsp_drive_clamped !== want.drive_clamped) begin
               $display("%0t: drive_clamped expected %0b actual %0b",
                        $time, want.drive_clamped, rsp_drive_clamped);
               errors++;
            end
         end
      end
   end

   // Watchdog: too long without any word moving on any channel ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         stalled_cycles <= 0;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
         if (stalled_cycles >= WATCH_LIMIT) begin
            $display("pid_temperature_pwm_duty: mismatch");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_sensor_word <= '0;
      csr_valid       <= 1'b0;
      csr_index       <= pidtpd_pkg::CSR_SETPOINT;
      csr_data        <= '0;
      reset_model();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_corner_settings();
      test_random_settings();

      // all duty words back, then a quiet stretch for anything stray
      wait_idle();
      if (errors == 0 && expected_duty.size() == 0) begin
         $display("pid_temperature_pwm_duty: match");
      end else begin
         $display("pid_temperature_pwm_duty: mismatch");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/pidtpd_pkg.sv
rtl/core/pidtpd_mul.sv
rtl/core/pidtpd_seq.sv
rtl/core/pid_temperature_pwm_duty.sv
bench/tb_pid_temperature_pwm_duty.sv
